/* hw/rtl/sltc_pkg.sv */
// sltc_pkg: shared constants, types and character decode helpers for the
// text-line to CAN frame parser. No dependencies.
`timescale 1ns / 1ps

package sltc_pkg;

    localparam int LINE_CAPACITY_DEF = 32;

    // digit positions that can ever feed a frame (kind char at 0, last data digit at 25)
    localparam int DIGIT_SLOTS = 26;
    localparam int SLOT_W      = $clog2(DIGIT_SLOTS);

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_STD = 8'h74;
    localparam logic [7:0] CH_EXT = 8'h54;

    localparam int ID_SLOT       = 1;
    localparam int STD_LEN_SLOT  = 4;
    localparam int STD_DATA_SLOT = 5;
    localparam int EXT_LEN_SLOT  = 9;
    localparam int EXT_DATA_SLOT = 10;

    localparam logic [3:0] MAX_LENGTH = 4'd8;
    localparam int         NUM_BYTES  = 8;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_STD,
        KIND_EXT
    } line_kind_t;

    typedef struct packed {
        logic              is_cr;
        logic              wr_en;
        logic [SLOT_W-1:0] slot;
        logic [3:0]        digit;
        line_kind_t        kind;
    } char_entry_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

    function automatic line_kind_t classify_kind(input logic [7:0] c);
        line_kind_t k;
        k = KIND_NONE;
        if (c == CH_STD) begin
            k = KIND_STD;
        end else if (c == CH_EXT) begin
            k = KIND_EXT;
        end
        return k;
    endfunction

endpackage

/* hw/rtl/slcan_text_to_can_frame_top.sv */
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_rx_char[7:0]
// m_        out  m_valid/m_ready    is_extended, frame_id, data_length, data_byte_0..7
//
// one character is taken every cycle while s_ready is high; the digit store in the back end
// takes one write a cycle; a frame passes through the queue and then the result register
// before it shows on m_, and is held back only while an earlier frame still waits on m_ready
// aresetn is synchronous and active low; it clears line state and empties the queue
// s_ready drops only when the two-entry queue fills, i.e. while a finished frame waits on m_ready
//
// top level of the text-line to CAN frame parser; depends on sltc_pkg,
// sltc_front, sltc_fifo and sltc_back
`timescale 1ns / 1ps

module slcan_text_to_can_frame_top
    import sltc_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_extended,
    output logic [28:0] m_frame_id,
    output logic [3:0]  m_data_length,
    output logic [7:0]  m_data_byte_0,
    output logic [7:0]  m_data_byte_1,
    output logic [7:0]  m_data_byte_2,
    output logic [7:0]  m_data_byte_3,
    output logic [7:0]  m_data_byte_4,
    output logic [7:0]  m_data_byte_5,
    output logic [7:0]  m_data_byte_6,
    output logic [7:0]  m_data_byte_7
);

    logic        q_full;
    logic        q_push;
    char_entry_t q_entry;
    logic        q_pop;
    logic        q_valid;
    char_entry_t q_head;

    sltc_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_char (s_rx_char),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    sltc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .entry_in   (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    sltc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .head          (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_extended (m_is_extended),
        .m_frame_id    (m_frame_id),
        .m_data_length (m_data_length),
        .m_data_byte_0 (m_data_byte_0),
        .m_data_byte_1 (m_data_byte_1),
        .m_data_byte_2 (m_data_byte_2),
        .m_data_byte_3 (m_data_byte_3),
        .m_data_byte_4 (m_data_byte_4),
        .m_data_byte_5 (m_data_byte_5),
        .m_data_byte_6 (m_data_byte_6),
        .m_data_byte_7 (m_data_byte_7)
    );

endmodule

/* hw/rtl/sltc_front.sv */
// sltc_front: accepts characters, tracks line position and line kind,
// and tags each character for the back end. Depends on sltc_pkg.
`timescale 1ns / 1ps

module sltc_front
    import sltc_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_char,
    input  logic        q_full,
    output logic        q_push,
    output char_entry_t q_entry
);

    localparam int               POS_W    = $clog2(LINE_CAPACITY);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_CAPACITY - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    line_kind_t       kind_reg, kind_next;
    logic             accept;
    logic             is_cr;
    logic             room;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_cr   = (s_rx_char == CH_CR);
    assign room    = (pos_reg < LAST_POS);

    always_comb begin
        pos_next  = pos_reg;
        kind_next = kind_reg;
        if (accept) begin
            if (is_cr) begin
                pos_next  = '0;
                kind_next = KIND_NONE;
            end else if (room) begin
                if (pos_reg == '0) begin
                    kind_next = classify_kind(s_rx_char);
                end
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_comb begin
        q_push        = accept;
        q_entry.is_cr = is_cr;
        // slot 0 is the kind character, never a digit of the frame
        q_entry.wr_en = !is_cr && room && (pos_reg < POS_W'(DIGIT_SLOTS)) && (pos_reg != '0);
        q_entry.slot  = SLOT_W'(pos_reg);
        q_entry.digit = hex_value(s_rx_char);
        q_entry.kind  = kind_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            kind_reg <= KIND_NONE;
        end else begin
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
        end
    end

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("line position past capacity");

    a_cr_restarts_line: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_cr |=> pos_reg == '0 && kind_reg == KIND_NONE)
        else $error("line state not cleared after carriage return");

endmodule

/* hw/rtl/sltc_fifo.sv */
// sltc_fifo: short queue of tagged characters between front and back end.
// Depends on sltc_pkg.
`timescale 1ns / 1ps

module sltc_fifo
    import sltc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  char_entry_t entry_in,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output char_entry_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    char_entry_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

endmodule

/* hw/rtl/sltc_back.sv */
// sltc_back: keeps the digits of the current line and builds the frame on the
// carriage return of a standard or extended line into the result register. Depends on sltc_pkg.
`timescale 1ns / 1ps

module sltc_back
    import sltc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  char_entry_t head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_extended,
    output logic [28:0] m_frame_id,
    output logic [3:0]  m_data_length,
    output logic [7:0]  m_data_byte_0,
    output logic [7:0]  m_data_byte_1,
    output logic [7:0]  m_data_byte_2,
    output logic [7:0]  m_data_byte_3,
    output logic [7:0]  m_data_byte_4,
    output logic [7:0]  m_data_byte_5,
    output logic [7:0]  m_data_byte_6,
    output logic [7:0]  m_data_byte_7
);

    logic [3:0]  digit_reg [DIGIT_SLOTS];

    logic        m_valid_reg, m_valid_next;
    logic        ext_reg;
    logic [28:0] id_reg;
    logic [3:0]  len_reg;
    logic [7:0]  byte_reg [NUM_BYTES];

    logic        frame_line;
    logic        out_free;
    logic        emit;
    logic        ext_calc;
    logic [11:0] std_id;
    logic [31:0] ext_id;
    logic [28:0] id_calc;
    logic [3:0]  len_raw;
    logic [3:0]  len_calc;
    logic [7:0]  byte_calc [NUM_BYTES];

    assign frame_line = head.is_cr && (head.kind != KIND_NONE);
    assign out_free   = !m_valid_reg || m_ready;
    // only a frame-ending carriage return waits on the result register
    assign q_pop      = q_valid && (!frame_line || out_free);
    assign emit       = q_pop && frame_line;

    always_comb begin
        ext_calc = (head.kind == KIND_EXT);
        std_id   = {digit_reg[ID_SLOT], digit_reg[ID_SLOT + 1], digit_reg[ID_SLOT + 2]};
        ext_id   = {digit_reg[ID_SLOT],     digit_reg[ID_SLOT + 1],
                    digit_reg[ID_SLOT + 2], digit_reg[ID_SLOT + 3],
                    digit_reg[ID_SLOT + 4], digit_reg[ID_SLOT + 5],
                    digit_reg[ID_SLOT + 6], digit_reg[ID_SLOT + 7]};
        id_calc  = ext_calc ? ext_id[28:0] : {18'd0, std_id[10:0]};
        len_raw  = ext_calc ? digit_reg[EXT_LEN_SLOT] : digit_reg[STD_LEN_SLOT];
        len_calc = (len_raw > MAX_LENGTH) ? MAX_LENGTH : len_raw;
        for (int i = 0; i < NUM_BYTES; i++) begin
            if (4'(i) < len_calc) begin
                byte_calc[i] = ext_calc
                    ? {digit_reg[EXT_DATA_SLOT + 2*i], digit_reg[EXT_DATA_SLOT + 2*i + 1]}
                    : {digit_reg[STD_DATA_SLOT + 2*i], digit_reg[STD_DATA_SLOT + 2*i + 1]};
            end else begin
                byte_calc[i] = 8'h00;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // digits not yet received in this line read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIGIT_SLOTS; i++) begin
                digit_reg[i] <= 4'h0;
            end
        end else if (q_pop) begin
            if (head.is_cr) begin
                for (int i = 0; i < DIGIT_SLOTS; i++) begin
                    digit_reg[i] <= 4'h0;
                end
            end else if (head.wr_en) begin
                digit_reg[head.slot] <= head.digit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            ext_reg <= ext_calc;
            id_reg  <= id_calc;
            len_reg <= len_calc;
            for (int i = 0; i < NUM_BYTES; i++) begin
                byte_reg[i] <= byte_calc[i];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_is_extended = ext_reg;
    assign m_frame_id    = id_reg;
    assign m_data_length = len_reg;
    assign m_data_byte_0 = byte_reg[0];
    assign m_data_byte_1 = byte_reg[1];
    assign m_data_byte_2 = byte_reg[2];
    assign m_data_byte_3 = byte_reg[3];
    assign m_data_byte_4 = byte_reg[4];
    assign m_data_byte_5 = byte_reg[5];
    assign m_data_byte_6 = byte_reg[6];
    assign m_data_byte_7 = byte_reg[7];

    a_len_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> len_reg <= MAX_LENGTH)
        else $error("data length above eight");

    a_std_id_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !ext_reg |-> id_reg[28:11] == '0)
        else $error("standard identifier wider than 11 bits");

endmodule
